### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

### hw/rtl/jwap_pkg.sv
// Shared types, codes and character constants of the word array parser
package jwap_pkg;

    localparam int DEF_LEN_BITS   = 16;
    localparam int DEF_COUNT_BITS = 16;
    localparam int FIFO_DEPTH     = 4;

    // Parse phases
    localparam logic [2:0] PH_SEEK_KEY     = 3'd0;
    localparam logic [2:0] PH_SEEK_BRACKET = 3'd1;
    localparam logic [2:0] PH_EXPECT_STR   = 3'd2;
    localparam logic [2:0] PH_IN_STR       = 3'd3;
    localparam logic [2:0] PH_AFTER_ITEM   = 3'd4;
    localparam logic [2:0] PH_DONE         = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_CHAR     = 2'd0;
    localparam logic [1:0] KIND_WORD_END = 2'd1;
    localparam logic [1:0] KIND_SUMMARY  = 2'd2;

    // Summary status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_KEY      = 3'd1;
    localparam logic [2:0] ST_NO_BRACKET  = 3'd2;
    localparam logic [2:0] ST_EMPTY_ARRAY = 3'd3;
    localparam logic [2:0] ST_BAD_STRING  = 3'd4;
    localparam logic [2:0] ST_BAD_SEP     = 3'd5;
    localparam logic [2:0] ST_NO_WORDS    = 3'd6;

    // Characters
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;

    localparam logic [2:0] KEY_LAST = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_char;
        logic [15:0] word_length;
        logic [15:0] num_words;
        logic [15:0] shortest;
        logic [15:0] longest;
        logic [2:0]  status;
    } result_t;

    // Up to two results produced by one byte
    typedef struct packed {
        logic    v0;
        result_t r0;
        logic    v1;
        result_t r1;
    } step_t;

    // Characters of the quoted key "words"
    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_QUOTE;
            3'd1:    c = 8'h77;
            3'd2:    c = 8'h6F;
            3'd3:    c = 8'h72;
            3'd4:    c = 8'h64;
            3'd5:    c = 8'h73;
            3'd6:    c = CH_QUOTE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_LF) || (b == CH_CR) || (b == CH_TAB);
    endfunction

endpackage

### hw/rtl/jwap_core.sv
// Parse state machine: one byte per cycle while fire is high, up to two results per byte
module jwap_core #(
    parameter int LEN_BITS   = jwap_pkg::DEF_LEN_BITS,
    parameter int COUNT_BITS = jwap_pkg::DEF_COUNT_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      in_byte,
    input  logic            last_byte,
    output jwap_pkg::step_t step
);

    logic [2:0]            phase_reg, phase_next;
    logic [2:0]            key_reg, key_next;
    logic                  esc_reg, esc_next;
    logic [LEN_BITS-1:0]   len_reg, len_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [LEN_BITS-1:0]   sh_reg, sh_next;
    logic [LEN_BITS-1:0]   lo_reg, lo_next;
    logic                  first_reg, first_next;
    logic [7:0]            dec_char;
    logic                  dec_ok;
    logic [2:0]            end_status;

    function automatic jwap_pkg::result_t make_summary(
        input logic [COUNT_BITS-1:0] cnt,
        input logic [LEN_BITS-1:0]   sh,
        input logic [LEN_BITS-1:0]   lo,
        input logic [2:0]            st
    );
        jwap_pkg::result_t r;
        r             = '0;
        r.kind        = jwap_pkg::KIND_SUMMARY;
        r.num_words   = 16'(cnt);
        r.shortest    = 16'(sh);
        r.longest     = 16'(lo);
        r.status      = st;
        return r;
    endfunction

    function automatic jwap_pkg::result_t make_char(input logic [7:0] c);
        jwap_pkg::result_t r;
        r          = '0;
        r.kind     = jwap_pkg::KIND_CHAR;
        r.out_char = c;
        return r;
    endfunction

    // Escape decode
    always_comb
    begin
        dec_ok   = 1'b1;
        dec_char = in_byte;
        case (in_byte) inside
            jwap_pkg::CH_N: dec_char = jwap_pkg::CH_LF;
            jwap_pkg::CH_R: dec_char = jwap_pkg::CH_CR;
            jwap_pkg::CH_T: dec_char = jwap_pkg::CH_TAB;
            jwap_pkg::CH_QUOTE, jwap_pkg::CH_BSLASH, jwap_pkg::CH_SLASH: dec_char = in_byte;
            default: dec_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        key_next   = key_reg;
        esc_next   = esc_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        sh_next    = sh_reg;
        lo_next    = lo_reg;
        first_next = first_reg;
        end_status = jwap_pkg::ST_OK;
        step       = '0;

        if (fire)
        begin
            unique case (phase_reg)
                jwap_pkg::PH_SEEK_KEY:
                begin
                    if (in_byte == jwap_pkg::key_char(key_reg))
                    begin
                        if (key_reg == jwap_pkg::KEY_LAST)
                        begin
                            key_next   = '0;
                            phase_next = jwap_pkg::PH_SEEK_BRACKET;
                        end
                        else
                        begin
                            key_next = key_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        key_next = (in_byte == jwap_pkg::CH_QUOTE) ? 3'd1 : 3'd0;
                    end
                end
                jwap_pkg::PH_SEEK_BRACKET:
                begin
                    if (in_byte == jwap_pkg::CH_LBRACK)
                    begin
                        phase_next = jwap_pkg::PH_EXPECT_STR;
                        first_next = 1'b1;
                    end
                end
                jwap_pkg::PH_EXPECT_STR:
                begin
                    if (jwap_pkg::is_ws(in_byte))
                    begin
                        phase_next = phase_reg;
                    end
                    else if (first_reg && in_byte == jwap_pkg::CH_RBRACK)
                    begin
                        step.v0    = 1'b1;
                        step.r0    = make_summary(cnt_reg, sh_reg, lo_reg,
                                                  jwap_pkg::ST_EMPTY_ARRAY);
                        phase_next = jwap_pkg::PH_DONE;
                    end
                    else if (in_byte == jwap_pkg::CH_QUOTE)
                    begin
                        phase_next = jwap_pkg::PH_IN_STR;
                        len_next   = '0;
                        esc_next   = 1'b0;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        step.v0    = 1'b1;
                        step.r0    = make_summary(cnt_reg, sh_reg, lo_reg,
                                                  jwap_pkg::ST_BAD_STRING);
                        phase_next = jwap_pkg::PH_DONE;
                    end
                end
                jwap_pkg::PH_IN_STR:
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        step.v0  = 1'b1;
                        if (dec_ok)
                        begin
                            step.r0 = make_char(dec_char);
                            if (len_reg != '1)
                                len_next = len_reg + LEN_BITS'(1);
                        end
                        else
                        begin
                            step.r0    = make_summary(cnt_reg, sh_reg, lo_reg,
                                                      jwap_pkg::ST_BAD_STRING);
                            phase_next = jwap_pkg::PH_DONE;
                        end
                    end
                    else if (in_byte == jwap_pkg::CH_BSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (in_byte == jwap_pkg::CH_QUOTE)
                    begin
                        // close the word: fold its length into the running stats
                        if (cnt_reg == '0 || len_reg < sh_reg)
                            sh_next = len_reg;
                        if (len_reg > lo_reg)
                            lo_next = len_reg;
                        if (cnt_reg != '1)
                            cnt_next = cnt_reg + COUNT_BITS'(1);
                        step.v0             = 1'b1;
                        step.r0.kind        = jwap_pkg::KIND_WORD_END;
                        step.r0.word_length = 16'(len_reg);
                        phase_next          = jwap_pkg::PH_AFTER_ITEM;
                    end
                    else
                    begin
                        step.v0 = 1'b1;
                        step.r0 = make_char(in_byte);
                        if (len_reg != '1)
                            len_next = len_reg + LEN_BITS'(1);
                    end
                end
                jwap_pkg::PH_AFTER_ITEM:
                begin
                    if (jwap_pkg::is_ws(in_byte))
                    begin
                        phase_next = phase_reg;
                    end
                    else if (in_byte == jwap_pkg::CH_COMMA)
                    begin
                        phase_next = jwap_pkg::PH_EXPECT_STR;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        step.v0    = 1'b1;
                        step.r0    = make_summary(cnt_reg, sh_reg, lo_reg,
                                         (in_byte == jwap_pkg::CH_RBRACK) ?
                                         jwap_pkg::ST_OK : jwap_pkg::ST_BAD_SEP);
                        phase_next = jwap_pkg::PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            if (last_byte)
            begin
                unique case (phase_next)
                    jwap_pkg::PH_SEEK_KEY:     end_status = jwap_pkg::ST_NO_KEY;
                    jwap_pkg::PH_SEEK_BRACKET: end_status = jwap_pkg::ST_NO_BRACKET;
                    jwap_pkg::PH_EXPECT_STR:
                        end_status = first_next ? jwap_pkg::ST_NO_WORDS
                                                : jwap_pkg::ST_BAD_STRING;
                    jwap_pkg::PH_IN_STR:       end_status = jwap_pkg::ST_BAD_STRING;
                    default:                   end_status = jwap_pkg::ST_OK;
                endcase
                // pending summary from the end of the document
                step.v1 = (phase_next != jwap_pkg::PH_DONE);
                step.r1 = make_summary(cnt_next, sh_next, lo_next, end_status);

                phase_next = jwap_pkg::PH_SEEK_KEY;
                key_next   = '0;
                esc_next   = 1'b0;
                len_next   = '0;
                cnt_next   = '0;
                sh_next    = '0;
                lo_next    = '0;
                first_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jwap_pkg::PH_SEEK_KEY;
            key_reg   <= '0;
            esc_reg   <= 1'b0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            sh_reg    <= '0;
            lo_reg    <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            key_reg   <= key_next;
            esc_reg   <= esc_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            sh_reg    <= sh_next;
            lo_reg    <= lo_next;
            first_reg <= first_next;
        end
    end

endmodule

### hw/rtl/jwap_out_fifo.sv
// Result queue: takes up to two results a cycle, hands out one per beat
module jwap_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  jwap_pkg::step_t   push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output jwap_pkg::result_t out_data
);

    localparam int DEPTH = jwap_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    jwap_pkg::result_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        n_push;
    logic              pop;
    jwap_pkg::result_t first_item;

    assign n_push     = 2'(push.v0) + 2'(push.v1);
    assign first_item = push.v0 ? push.r0 : push.r1;
    assign pop        = out_valid && out_ready;
    assign out_valid  = (cnt_reg != '0);
    assign out_data   = mem_reg[rd_reg];
    // keep space for the worst case of two results from one byte
    assign room       = (cnt_reg <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        wr_next  = wr_reg + PTR_W'(n_push);
        rd_next  = rd_reg + PTR_W'(pop);
        cnt_next = cnt_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            mem_reg[wr_reg] <= first_item;
        if (push.v0 && push.v1)
            mem_reg[wr_reg + PTR_W'(1)] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### hw/rtl/json_word_array_parser_top.sv
// An accepted byte waits in the input register; its results then go to the result queue that drives m_axis.
// Throughput: one byte per cycle; a byte giving two results (summary at the last
// byte after another result) costs an extra beat on m_axis, absorbed by the
// four-entry result queue; the input stalls while that queue holds three or more.
// Reset: rst_n low clears the parse state, the input valid flag and the queue;
// after each beat with tlast the parse state returns to its reset values.
module json_word_array_parser_top #(
    parameter int LEN_BITS   = jwap_pkg::DEF_LEN_BITS,
    parameter int COUNT_BITS = jwap_pkg::DEF_COUNT_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // out_char, word_length, num_words, shortest,
                                        // longest, status, zero pad
    output logic [1:0]  m_axis_tuser    // kind
);

    logic              in_v_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              room;
    logic              proc;
    jwap_pkg::step_t   step;
    jwap_pkg::result_t head;

    assign proc          = in_v_reg && room;
    assign s_axis_tready = !in_v_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (s_axis_tready)
            in_v_reg <= s_axis_tvalid;
    end

    // hold the byte until the core takes it
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    jwap_core #(
        .LEN_BITS   (LEN_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (proc),
        .in_byte   (in_byte_reg),
        .last_byte (in_last_reg),
        .step      (step)
    );

    jwap_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head)
    );

    assign m_axis_tuser = head.kind;
    assign m_axis_tdata = {5'b0, head.status, head.longest, head.shortest,
                           head.num_words, head.word_length, head.out_char};

endmodule

### hw/rtl/jwap_checker.sv
// Port-level checks on the parser's input stall and result stream
`include "assert_macros.svh"

module jwap_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic is_char;
    logic is_end;
    logic is_sum;

    assign is_char = m_axis_tvalid && (m_axis_tuser == jwap_pkg::KIND_CHAR);
    assign is_end  = m_axis_tvalid && (m_axis_tuser == jwap_pkg::KIND_WORD_END);
    assign is_sum  = m_axis_tvalid && (m_axis_tuser == jwap_pkg::KIND_SUMMARY);

    // a stalled result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // the input is held off only while results are queued
    `ASSERT_IMPLIES(a_in_stall, clk, rst_n, s_axis_tvalid && !s_axis_tready, m_axis_tvalid)
    // a character beat carries nothing but the character
    `ASSERT_IMPLIES(a_char_clean, clk, rst_n, is_char, m_axis_tdata[79:8] == '0)
    // a word end carries only the length
    `ASSERT_IMPLIES(a_end_clean, clk, rst_n, is_end,
        m_axis_tdata[7:0] == '0 && m_axis_tdata[79:24] == '0)
    // a summary carries a defined status and no character or length
    `ASSERT_IMPLIES(a_sum_status, clk, rst_n, is_sum,
        m_axis_tdata[74:72] != 3'd7 && m_axis_tdata[23:0] == '0)

endmodule

bind json_word_array_parser_top jwap_checker u_jwap_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/tb_json_word_array_parser_top.sv
// Self-checking testbench of the streaming "words" array parser
`timescale 1ns / 100ps

module tb_json_word_array_parser_top;

    localparam int HOLD_CYCLES = 200;

    // Expected result beats of the parser, worked out byte by byte
    class word_list_scoreboard;
        logic [2:0]  phase;
        int          key_pos;
        bit          escape_pending;
        bit          just_opened;
        logic [15:0] cur_len;
        logic [15:0] word_total;
        logic [15:0] min_len;
        logic [15:0] max_len;
        string       key_text;
        jwap_pkg::result_t expected_beats[$];
        int          mismatches;
        int          beats_checked;
        bit [6:0]    status_seen;

        function new();
            key_text      = "\"words\"";
            mismatches    = 0;
            beats_checked = 0;
            status_seen   = '0;
            clear();
        endfunction

        function void clear();
            phase          = jwap_pkg::PH_SEEK_KEY;
            key_pos        = 0;
            escape_pending = 0;
            just_opened    = 0;
            cur_len        = '0;
            word_total     = '0;
            min_len        = '0;
            max_len        = '0;
        endfunction

        function void push_beat(logic [1:0] k, logic [7:0] ch, logic [15:0] len,
                                logic [15:0] cnt, logic [15:0] sh, logic [15:0] lg,
                                logic [2:0] st);
            jwap_pkg::result_t r;
            r.kind        = k;
            r.out_char    = ch;
            r.word_length = len;
            r.num_words   = cnt;
            r.shortest    = sh;
            r.longest     = lg;
            r.status      = st;
            expected_beats.push_back(r);
        endfunction

        function void close_doc(logic [2:0] st);
            push_beat(jwap_pkg::KIND_SUMMARY, 8'h00, 16'h0, word_total, min_len, max_len,
                      st);
            status_seen[st] = 1'b1;
            phase = jwap_pkg::PH_DONE;
        endfunction

        function void emit_char(logic [7:0] c);
            push_beat(jwap_pkg::KIND_CHAR, c, 16'h0, 16'h0, 16'h0, 16'h0, jwap_pkg::ST_OK);
            if (cur_len != 16'hFFFF)
                cur_len++;
        endfunction

        function bit is_blank(logic [7:0] b);
            return b == jwap_pkg::CH_SPACE || b == jwap_pkg::CH_LF ||
                   b == jwap_pkg::CH_CR || b == jwap_pkg::CH_TAB;
        endfunction

        // Advance the parse by one accepted byte
        function void note_byte(logic [7:0] b, logic last);
            case (phase)
                jwap_pkg::PH_SEEK_KEY:
                    if (key_pos < 7 && b == key_text[key_pos])
                    begin
                        key_pos++;
                        if (key_pos == 7)
                        begin
                            key_pos = 0;
                            phase   = jwap_pkg::PH_SEEK_BRACKET;
                        end
                    end
                    else
                        key_pos = (b == jwap_pkg::CH_QUOTE) ? 1 : 0;
                jwap_pkg::PH_SEEK_BRACKET:
                    if (b == jwap_pkg::CH_LBRACK)
                    begin
                        phase       = jwap_pkg::PH_EXPECT_STR;
                        just_opened = 1;
                    end
                jwap_pkg::PH_EXPECT_STR:
                    if (is_blank(b))
                        ;
                    else if (just_opened && b == jwap_pkg::CH_RBRACK)
                        close_doc(jwap_pkg::ST_EMPTY_ARRAY);
                    else if (b == jwap_pkg::CH_QUOTE)
                    begin
                        phase          = jwap_pkg::PH_IN_STR;
                        cur_len        = '0;
                        escape_pending = 0;
                        just_opened    = 0;
                    end
                    else
                        close_doc(jwap_pkg::ST_BAD_STRING);
                jwap_pkg::PH_IN_STR:
                    if (escape_pending)
                    begin
                        escape_pending = 0;
                        case (b) inside
                            jwap_pkg::CH_N: emit_char(jwap_pkg::CH_LF);
                            jwap_pkg::CH_R: emit_char(jwap_pkg::CH_CR);
                            jwap_pkg::CH_T: emit_char(jwap_pkg::CH_TAB);
                            jwap_pkg::CH_QUOTE, jwap_pkg::CH_BSLASH, jwap_pkg::CH_SLASH:
                                emit_char(b);
                            default: close_doc(jwap_pkg::ST_BAD_STRING);
                        endcase
                    end
                    else if (b == jwap_pkg::CH_BSLASH)
                        escape_pending = 1;
                    else if (b == jwap_pkg::CH_QUOTE)
                    begin
                        if (word_total == 0 || cur_len < min_len)
                            min_len = cur_len;
                        if (cur_len > max_len)
                            max_len = cur_len;
                        if (word_total != 16'hFFFF)
                            word_total++;
                        push_beat(jwap_pkg::KIND_WORD_END, 8'h00, cur_len, 16'h0, 16'h0,
                                  16'h0, jwap_pkg::ST_OK);
                        phase = jwap_pkg::PH_AFTER_ITEM;
                    end
                    else
                        emit_char(b);
                jwap_pkg::PH_AFTER_ITEM:
                    if (is_blank(b))
                        ;
                    else if (b == jwap_pkg::CH_COMMA)
                    begin
                        phase       = jwap_pkg::PH_EXPECT_STR;
                        just_opened = 0;
                    end
                    else if (b == jwap_pkg::CH_RBRACK)
                        close_doc(jwap_pkg::ST_OK);
                    else
                        close_doc(jwap_pkg::ST_BAD_SEP);
                default:
                    ;
            endcase

            if (last)
            begin
                case (phase)
                    jwap_pkg::PH_SEEK_KEY:     close_doc(jwap_pkg::ST_NO_KEY);
                    jwap_pkg::PH_SEEK_BRACKET: close_doc(jwap_pkg::ST_NO_BRACKET);
                    jwap_pkg::PH_EXPECT_STR:
                        close_doc(just_opened ? jwap_pkg::ST_NO_WORDS
                                              : jwap_pkg::ST_BAD_STRING);
                    jwap_pkg::PH_IN_STR:       close_doc(jwap_pkg::ST_BAD_STRING);
                    jwap_pkg::PH_AFTER_ITEM:   close_doc(jwap_pkg::ST_OK);
                    default:                   ;
                endcase
                clear();
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_beat(logic [1:0] kind, logic [79:0] data);
            jwap_pkg::result_t want;
            beats_checked++;
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat, expected none, actual kind %0d data %h",
                         $time, kind, data);
                return;
            end
            want = expected_beats.pop_front();
            compare_field("kind",        16'(want.kind),        16'(kind));
            compare_field("out_char",    16'(want.out_char),    16'(data[7:0]));
            compare_field("word_length", want.word_length,      data[23:8]);
            compare_field("num_words",   want.num_words,        data[39:24]);
            compare_field("shortest",    want.shortest,         data[55:40]);
            compare_field("longest",     want.longest,          data[71:56]);
            compare_field("status",      16'(want.status),      16'(data[74:72]));
            compare_field("pad",         16'h0,                 16'(data[79:75]));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    word_list_scoreboard sb = new();

    logic [7:0] doc[$];
    bit         tx_gaps = 1'b0;
    bit         rx_gaps = 1'b0;
    bit         hold_req = 1'b0;
    int         docs_sent = 0;
    int         bytes_sent = 0;

    json_word_array_parser_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_beat(m_axis_tuser, m_axis_tdata);
        end
    end

    // Result sink: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (rx_gaps && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #100_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            doc.push_back(s[i]);
    endfunction

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 3))
            0:       return jwap_pkg::CH_SPACE;
            1:       return jwap_pkg::CH_LF;
            2:       return jwap_pkg::CH_CR;
            default: return jwap_pkg::CH_TAB;
        endcase
    endfunction

    function automatic void add_blanks(int most);
        repeat ($urandom_range(0, most)) doc.push_back(blank_byte());
    endfunction

    function automatic logic [7:0] escape_byte();
        case ($urandom_range(0, 5))
            0:       return jwap_pkg::CH_N;
            1:       return jwap_pkg::CH_R;
            2:       return jwap_pkg::CH_T;
            3:       return jwap_pkg::CH_QUOTE;
            4:       return jwap_pkg::CH_BSLASH;
            default: return jwap_pkg::CH_SLASH;
        endcase
    endfunction

    // Any byte that neither closes a string nor starts an escape
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == jwap_pkg::CH_QUOTE || b == jwap_pkg::CH_BSLASH)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] breaking_byte();
        case ($urandom_range(0, 6))
            0:       return jwap_pkg::CH_RBRACK;
            1:       return jwap_pkg::CH_COMMA;
            2:       return jwap_pkg::CH_QUOTE;
            3:       return jwap_pkg::CH_BSLASH;
            4:       return jwap_pkg::CH_LBRACK;
            5:       return 8'h78;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_word(int most);
        doc.push_back(jwap_pkg::CH_QUOTE);
        repeat ($urandom_range(0, most))
        begin
            case ($urandom_range(0, 9)) inside
                0, 1:
                begin
                    doc.push_back(jwap_pkg::CH_BSLASH);
                    doc.push_back(escape_byte());
                end
                2, 3:    doc.push_back(plain_byte());
                default: doc.push_back(8'h61 + 8'($urandom_range(0, 25)));
            endcase
        end
        doc.push_back(jwap_pkg::CH_QUOTE);
    endfunction

    // Mostly well-formed documents, some of them broken, the rest noise
    function automatic void build_doc();
        int sel;
        int words;
        int pos;
        doc.delete();
        sel = $urandom_range(0, 99);
        if (sel < 12)
        begin
            repeat ($urandom_range(1, 12)) doc.push_back(8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 5))
            0: repeat ($urandom_range(1, 5)) doc.push_back(8'($urandom_range(0, 255)));
            1: add_text("\"wo");
            2: add_text("{ ");
            default: ;
        endcase
        add_text("\"words\"");
        if ($urandom_range(0, 1))
        begin
            doc.push_back(8'h3A);
            add_blanks(2);
        end
        doc.push_back(jwap_pkg::CH_LBRACK);
        add_blanks(2);
        words = $urandom_range(0, 5);
        for (int w = 0; w < words; w++)
        begin
            if (w > 0)
            begin
                add_blanks(1);
                doc.push_back(jwap_pkg::CH_COMMA);
                add_blanks(1);
            end
            add_word(8);
        end
        add_blanks(1);
        // leave the array open now and then: the document ends instead
        if ($urandom_range(0, 4) != 0)
            doc.push_back(jwap_pkg::CH_RBRACK);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) doc.push_back(8'($urandom_range(0, 255)));
        if (sel >= 78)
        begin
            pos = $urandom_range(0, doc.size() - 1);
            case ($urandom_range(0, 2))
                0:       repeat (doc.size() - pos - 1) void'(doc.pop_back());
                1:       doc[pos] = breaking_byte();
                default: doc.insert(pos, breaking_byte());
            endcase
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (tx_gaps && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_doc();
        for (int i = 0; i < doc.size(); i++)
            send_byte(doc[i], i == doc.size() - 1);
        docs_sent++;
    endtask

    // Stop offering bytes and let every outstanding beat come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no key, with a zero byte
        doc = '{8'hFF, 8'h00};
        send_doc();
        // escaped word, then a byte after the summary that must be dropped
        doc.delete();
        add_text("\"words\"[\"a\\n\"]");
        doc.push_back(8'h80);
        send_doc();
        doc.delete();
        add_text("\"words\"[]");
        send_doc();

        while (bytes_sent < 600)
        begin
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            if (!held && bytes_sent > 200)
            begin
                // hold the sink off while a long word keeps the input busy
                held     = 1'b1;
                tx_gaps  = 1'b0;
                hold_req = 1'b1;
                doc.delete();
                add_text("\"words\"[\"");
                repeat (40) doc.push_back(8'h61 + 8'($urandom_range(0, 25)));
                add_text("\"]");
            end
            else
            begin
                if (!paused && bytes_sent > 400)
                begin
                    paused = 1'b1;
                    drain_results();
                end
                build_doc();
            end
            send_doc();
        end

        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        while (bytes_sent < 750)
        begin
            build_doc();
            send_doc();
        end

        // one short word, then an empty one
        doc.delete();
        add_text("\"words\"[\"");
        repeat (6) doc.push_back(8'h61 + 8'($urandom_range(0, 25)));
        add_text("\",\"\"]");
        send_doc();

        drain_results();
        $display("Sent %0d documents, %0d bytes; checked %0d result beats",
                 docs_sent, bytes_sent, sb.beats_checked);
        $display("Summary status codes reached (bit per code): %b", sb.status_seen);
        if (sb.mismatches == 0 && sb.expected_beats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
